@@ design/hsv_pixel_adjust_assert.svh @@
// Assertion macros used by the checker of the HSV pixel adjust block.
`ifndef HSV_PIXEL_ADJUST_ASSERT_SVH
`define HSV_PIXEL_ADJUST_ASSERT_SVH

// Clocked assertion that is switched off while reset is active.
`define HPA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked while reset is active.
`define HPA_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/hpa_pkg.sv @@
// Package with constants, types and helper functions of the HSV pixel adjust block.
package hpa_pkg;

    // Fixed-point scales.
    localparam int HUE_FULL    = 23040;
    localparam int HUE_SECTOR  = 3840;
    localparam int UNIT        = 65536;
    localparam int FACTOR_FULL = UNIT * HUE_SECTOR;
    // Reciprocal of 15 scaled by 2**19, exact for the quotients seen here.
    localparam int RECIP_15    = 34953;

    // Pipeline stage map.
    localparam int ST_IN       = 0;
    localparam int DIV_STEPS   = 17;
    localparam int H_DIV_FIRST = 6;
    localparam int ST_FIN      = DIV_STEPS + 1;
    localparam int ST_OFS      = ST_FIN + 1;
    localparam int ST_SEC      = ST_OFS + 1;
    localparam int ST_SW       = ST_SEC + 1;
    localparam int ST_PROD     = ST_SW + 1;
    localparam int ST_Y        = ST_PROD + 1;
    localparam int ST_OUT      = ST_Y + 1;
    localparam int NS          = ST_OUT + 1;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_HUE = 2'd0,
        CFG_SAT = 2'd1,
        CFG_VAL = 2'd2
    } t_cfg_idx;

    // One quotient bit of a restoring division.
    typedef struct packed {
        logic       q;
        logic [7:0] rem;
    } t_div;

    // Everything a pixel carries down the pipeline.
    typedef struct packed {
        logic             last;
        logic             grey;
        logic [7:0]       mx;
        logic [7:0]       dl;
        logic [16:0]      v;
        logic             neg;
        logic [2:0]       hb;
        logic [16:0]      s_lo;
        logic [7:0]       s_rem;
        logic [11:0]      h_lo;
        logic [7:0]       h_rem;
        logic [14:0]      h;
        logic [16:0]      s;
        logic [2:0]       sec;
        logic [11:0]      ff;
        logic [7:0]       vc;
        logic [2:0][28:0] sw;
        logic [2:0][44:0] prod;
        logic [2:0][12:0] y;
        logic [2:0][7:0]  ch;
    } t_pipe;

    // Shift one dividend bit into the remainder and try the subtraction.
    function automatic t_div div_bit(input logic [7:0] rem, input logic [7:0] d,
                                     input logic b);
        t_div       res;
        logic [8:0] r2;
        r2 = {rem, b};
        if (r2 >= {1'b0, d}) begin
            res.q   = 1'b1;
            res.rem = 8'(r2 - {1'b0, d});
        end else begin
            res.q   = 1'b0;
            res.rem = r2[7:0];
        end
        return res;
    endfunction

endpackage

@@ design/hpa_if.sv @@
// Stream and configuration interfaces of the HSV pixel adjust block.
interface hpa_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic       last_in;
    modport source (output valid, red_in, green_in, blue_in, last_in, input ready);
    modport sink   (input valid, red_in, green_in, blue_in, last_in, output ready);
endinterface

interface hpa_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       last_out;
    modport source (output valid, red_out, green_out, blue_out, last_out, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, last_out, output ready);
endinterface

interface hpa_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [17:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ design/hsv_pixel_adjust.sv @@
// Top level of the HSV pixel adjust block: RGB to HSV, offset and clamp, HSV to RGB.
// Throughput: one pixel per cycle when the output is not stalled; the depth is set by
// the 17-step bit-serial division pipeline for saturation and hue, followed by the
// offset and multiply stages.
// Each stage holds its beat when the next one is full, so a stall loses nothing.
// Reset (synchronous, active low) clears all valid bits and sets the three offsets to 0.
module hsv_pixel_adjust
    import hpa_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    hpa_in_if.sink   i_pix,
    hpa_out_if.source o_pix,
    hpa_cfg_if.sink  i_cfg
);

    logic signed [15:0] r_hue_off;
    logic signed [17:0] r_sat_off;
    logic signed [17:0] r_val_off;

    t_pipe            r_p   [NS];
    t_pipe            n_p   [NS];
    logic [NS-1:0]    r_vld;
    logic [NS-1:0]    en;

    // Configuration writes are always taken.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue_off <= '0;
            r_sat_off <= '0;
            r_val_off <= '0;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_HUE: r_hue_off <= i_cfg.data[15:0];
                CFG_SAT: r_sat_off <= i_cfg.data;
                CFG_VAL: r_val_off <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // A stage loads when it is empty or its content moves on.
    always_comb begin
        en[NS-1] = !r_vld[NS-1] || o_pix.ready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign i_pix.ready = en[0];

    // Next value of every stage.
    always_comb begin
        logic [7:0]         mx, mn, a;
        logic signed [8:0]  diff;
        logic [19:0]        nh;
        t_div               ds, dh;
        logic signed [17:0] hs;
        logic signed [19:0] ss, vs;
        logic [14:0]        hh;
        logic [11:0]        w [3];
        logic [52:0]        x;
        logic [28:0]        cq;
        logic [7:0]         c [3];
        logic [24:0]        vm;

        // Input stage: max, min, value and the division setup.
        mx = (i_pix.red_in > i_pix.green_in) ? i_pix.red_in : i_pix.green_in;
        mx = (mx > i_pix.blue_in) ? mx : i_pix.blue_in;
        mn = (i_pix.red_in < i_pix.green_in) ? i_pix.red_in : i_pix.green_in;
        mn = (mn < i_pix.blue_in) ? mn : i_pix.blue_in;
        n_p[ST_IN]      = r_p[ST_IN];
        n_p[ST_IN].last = i_pix.last_in;
        n_p[ST_IN].mx   = mx;
        n_p[ST_IN].dl   = mx - mn;
        n_p[ST_IN].grey = (mx == mn);
        n_p[ST_IN].v    = 17'(mx) * 17'd257 + 17'(mx != 8'd0);
        if (i_pix.red_in == mx) begin
            n_p[ST_IN].hb = 3'd0;
            diff = $signed({1'b0, i_pix.green_in}) - $signed({1'b0, i_pix.blue_in});
        end else if (i_pix.green_in == mx) begin
            n_p[ST_IN].hb = 3'd2;
            diff = $signed({1'b0, i_pix.blue_in}) - $signed({1'b0, i_pix.red_in});
        end else begin
            n_p[ST_IN].hb = 3'd4;
            diff = $signed({1'b0, i_pix.red_in}) - $signed({1'b0, i_pix.green_in});
        end
        n_p[ST_IN].neg   = diff[8];
        a                = diff[8] ? 8'(-diff) : diff[7:0];
        nh               = 20'(a) * 20'(HUE_SECTOR);
        n_p[ST_IN].h_rem = nh[19:12];
        n_p[ST_IN].h_lo  = nh[11:0];
        n_p[ST_IN].s_rem = {1'b0, n_p[ST_IN].dl[7:1]};
        n_p[ST_IN].s_lo  = {n_p[ST_IN].dl[0], 16'd0};

        // Division steps: saturation over all of them, hue over the last twelve.
        for (int k = 1; k <= DIV_STEPS; k++) begin
            n_p[k] = r_p[k-1];
            ds = div_bit(r_p[k-1].s_rem, r_p[k-1].mx, r_p[k-1].s_lo[16]);
            n_p[k].s_rem = ds.rem;
            n_p[k].s_lo  = {r_p[k-1].s_lo[15:0], ds.q};
            if (k >= H_DIV_FIRST) begin
                dh = div_bit(r_p[k-1].h_rem, r_p[k-1].dl, r_p[k-1].h_lo[11]);
                n_p[k].h_rem = dh.rem;
                n_p[k].h_lo  = {r_p[k-1].h_lo[10:0], dh.q};
            end
        end

        // Round saturation up and place the hue in its sector; grey has neither.
        // A negative difference counts down from the sector base, or from a full
        // turn when red is the maximum.
        n_p[ST_FIN] = r_p[ST_FIN-1];
        if (r_p[ST_FIN-1].grey) begin
            n_p[ST_FIN].h = '0;
            n_p[ST_FIN].s = '0;
        end else begin
            n_p[ST_FIN].s = r_p[ST_FIN-1].s_lo + 17'(r_p[ST_FIN-1].s_rem != 8'd0);
            if (r_p[ST_FIN-1].neg) begin
                n_p[ST_FIN].h = ((r_p[ST_FIN-1].hb == 3'd0) ? 15'(HUE_FULL)
                                 : 15'(r_p[ST_FIN-1].hb) * 15'(HUE_SECTOR))
                              - 15'(r_p[ST_FIN-1].h_lo)
                              - 15'(r_p[ST_FIN-1].h_rem != 8'd0);
            end else begin
                n_p[ST_FIN].h = 15'(r_p[ST_FIN-1].hb) * 15'(HUE_SECTOR)
                              + 15'(r_p[ST_FIN-1].h_lo);
            end
        end

        // Add the offsets and saturate.
        n_p[ST_OFS] = r_p[ST_OFS-1];
        hs = $signed({3'b0, r_p[ST_OFS-1].h}) + {{2{r_hue_off[15]}}, r_hue_off};
        ss = $signed({3'b0, r_p[ST_OFS-1].s}) + {{2{r_sat_off[17]}}, r_sat_off};
        vs = $signed({3'b0, r_p[ST_OFS-1].v}) + {{2{r_val_off[17]}}, r_val_off};
        if (hs < 0)                 n_p[ST_OFS].h = '0;
        else if (hs > HUE_FULL)     n_p[ST_OFS].h = 15'(HUE_FULL);
        else                        n_p[ST_OFS].h = hs[14:0];
        if (ss < 0)                 n_p[ST_OFS].s = '0;
        else if (ss > UNIT)         n_p[ST_OFS].s = 17'(UNIT);
        else                        n_p[ST_OFS].s = ss[16:0];
        if (vs < 0)                 n_p[ST_OFS].v = '0;
        else if (vs > UNIT)         n_p[ST_OFS].v = 17'(UNIT);
        else                        n_p[ST_OFS].v = vs[16:0];

        // Sector and fraction; a full turn counts as hue zero.
        n_p[ST_SEC] = r_p[ST_SEC-1];
        hh = (r_p[ST_SEC-1].h == 15'(HUE_FULL)) ? 15'd0 : r_p[ST_SEC-1].h;
        n_p[ST_SEC].sec = 3'(hh >= 15'(HUE_SECTOR))     + 3'(hh >= 15'(2 * HUE_SECTOR))
                        + 3'(hh >= 15'(3 * HUE_SECTOR)) + 3'(hh >= 15'(4 * HUE_SECTOR))
                        + 3'(hh >= 15'(5 * HUE_SECTOR));
        n_p[ST_SEC].ff  = 12'(hh - 15'(n_p[ST_SEC].sec) * 15'(HUE_SECTOR));
        vm = 25'(r_p[ST_SEC-1].v) * 25'd255;
        n_p[ST_SEC].vc  = vm[23:16];

        // Saturation times the weights of p, q and t.
        n_p[ST_SW] = r_p[ST_SW-1];
        w[0] = 12'(HUE_SECTOR);
        w[1] = r_p[ST_SW-1].ff;
        w[2] = 12'(HUE_SECTOR) - r_p[ST_SW-1].ff;
        for (int i = 0; i < 3; i++) begin
            n_p[ST_SW].sw[i] = 29'(r_p[ST_SW-1].s) * 29'(w[i]);
        end

        // Value times the scale factors.
        n_p[ST_PROD] = r_p[ST_PROD-1];
        for (int i = 0; i < 3; i++) begin
            n_p[ST_PROD].prod[i] = 45'(r_p[ST_PROD-1].v)
                                 * 45'(28'(29'(FACTOR_FULL) - r_p[ST_PROD-1].sw[i]));
        end

        // Times 255, then the power-of-two part of the divisor.
        n_p[ST_Y] = r_p[ST_Y-1];
        for (int i = 0; i < 3; i++) begin
            x = {r_p[ST_Y-1].prod[i], 8'd0} - 53'(r_p[ST_Y-1].prod[i]);
            n_p[ST_Y].y[i] = x[52:40];
        end

        // Divide by 15 and route p, q and t by sector.
        n_p[ST_OUT] = r_p[ST_OUT-1];
        for (int i = 0; i < 3; i++) begin
            cq   = 29'(r_p[ST_OUT-1].y[i]) * 29'(RECIP_15);
            c[i] = cq[26:19];
        end
        if (r_p[ST_OUT-1].s == 17'd0) begin
            n_p[ST_OUT].ch = {3{r_p[ST_OUT-1].vc}};
        end else begin
            case (r_p[ST_OUT-1].sec)
                3'd0:    n_p[ST_OUT].ch = {c[0], c[2], r_p[ST_OUT-1].vc};
                3'd1:    n_p[ST_OUT].ch = {c[0], r_p[ST_OUT-1].vc, c[1]};
                3'd2:    n_p[ST_OUT].ch = {c[2], r_p[ST_OUT-1].vc, c[0]};
                3'd3:    n_p[ST_OUT].ch = {r_p[ST_OUT-1].vc, c[1], c[0]};
                3'd4:    n_p[ST_OUT].ch = {r_p[ST_OUT-1].vc, c[0], c[2]};
                default: n_p[ST_OUT].ch = {c[1], c[0], r_p[ST_OUT-1].vc};
            endcase
        end
    end

    // Stage registers with their valid bits.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NS; k++) begin
            if (en[k]) begin
                r_p[k] <= n_p[k];
            end
        end
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_pix.valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Output beat; ch holds red, green, blue from the bottom up.
    assign o_pix.valid     = r_vld[NS-1];
    assign o_pix.red_out   = r_p[NS-1].ch[0];
    assign o_pix.green_out = r_p[NS-1].ch[1];
    assign o_pix.blue_out  = r_p[NS-1].ch[2];
    assign o_pix.last_out  = r_p[NS-1].last;

endmodule

@@ design/hpa_checker.sv @@
// Port-level checker of the HSV pixel adjust block and its bind statement.
`include "hsv_pixel_adjust_assert.svh"

module hpa_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_red,
    input logic [7:0] i_green,
    input logic [7:0] i_blue,
    input logic       i_last
);

    // Reset empties the pipeline on the next edge.
    `HPA_ASSERT_NR(a_rst_empty, i_clk, !i_rst_n |=> !i_out_valid, "output valid after reset")

    // An empty output stage means every stage can load, so input is taken.
    `HPA_ASSERT(a_ready_empty, i_clk, i_rst_n, !i_out_valid |-> i_in_ready, "input stalled with empty output")

    // A stalled output beat stays offered.
    `HPA_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid, "output beat dropped")

    // A stalled output beat keeps its payload.
    `HPA_ASSERT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> $stable(i_red) && $stable(i_green) && $stable(i_blue) && $stable(i_last), "output payload changed during stall")

    // An input beat taken with the output empty is followed by a ready input or a valid output.
    `HPA_ASSERT(a_in_seen, i_clk, i_rst_n, i_in_valid && i_in_ready && !i_out_valid |=> i_in_ready || i_out_valid, "input beat taken with no progress")

endmodule

bind hsv_pixel_adjust hpa_checker u_hpa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_red       (o_pix.red_out),
    .i_green     (o_pix.green_out),
    .i_blue      (o_pix.blue_out),
    .i_last      (o_pix.last_out)
);
